// ----- hdl/evad_pkg.sv -----
// Shared types and constants of the energy voice activity detector.
package evad_pkg;

  localparam int unsigned MAX_FRAME_SAMPLES = 4096;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MAG_W    = SAMPLE_W + 1;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned HANG_W   = 20;
  localparam int unsigned SUM_W    = 43;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned MUL_B_W  = MAG_W;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANGOVER_RELOAD  = 1'd1;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd500;
  localparam logic [HANG_W-1:0] HANGOVER_RESET  = 20'd8000;

  localparam logic [COUNT_W-1:0] FRAME_LIMIT = COUNT_W'(MAX_FRAME_SAMPLES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_THR_SQ,
    ST_THR_CNT,
    ST_JUDGE
  } state_t;

  typedef enum logic [1:0] {
    MUL_SQUARE,
    MUL_THR_SQ,
    MUL_THR_CNT
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     judge_en;
  } dp_cmd_t;

  typedef struct packed {
    logic in_command;
    logic frame_end;
    logic out_full;
  } dp_stat_t;

endpackage

// ----- hdl/evad_if.sv -----
// Handshake channel interfaces of the voice activity detector.
interface evad_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic signed [evad_pkg::SAMPLE_W-1:0] sample;
  logic                           frame_end;

  modport source (output valid, command, sample, frame_end, input ready);
  modport sink   (input valid, command, sample, frame_end, output ready);
endinterface

interface evad_out_if;
  logic valid;
  logic ready;
  logic speaking;

  modport source (output valid, speaking, input ready);
  modport sink   (input valid, speaking, output ready);
endinterface

interface evad_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [evad_pkg::CFG_IDX_W-1:0]    index;
  logic [evad_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/evad_ctrl.sv -----
// Sequencer that steps the shared multiplier through squaring and frame judgment.
module evad_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  evad_pkg::dp_stat_t stat,
  output evad_pkg::dp_cmd_t  cmd
);
  import evad_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.mul_sel  = MUL_SQUARE;
    cmd.acc_en   = 1'b0;
    cmd.judge_en = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // A clear command finishes in the transfer cycle itself.
          if (!stat.in_command) begin
            state_next = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SQUARE;
        state_next  = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.acc_en = 1'b1;
        state_next = stat.frame_end ? ST_THR_SQ : ST_IDLE;
      end
      ST_THR_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_THR_SQ;
        state_next  = ST_THR_CNT;
      end
      ST_THR_CNT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_THR_CNT;
        state_next  = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (!stat.out_full) begin
          cmd.judge_en = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/evad_dp.sv -----
// Datapath: shared multiplier, energy accumulator, hangover logic and result register.
module evad_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  evad_pkg::dp_cmd_t                     cmd,
  output evad_pkg::dp_stat_t                    stat,
  input  logic                                  in_command,
  input  logic signed [evad_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                                  in_frame_end,
  input  logic                                  cfg_valid,
  input  logic [evad_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [evad_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_speaking
);
  import evad_pkg::*;

  logic [THR_W-1:0]    energy_threshold;
  logic [HANG_W-1:0]   hangover_reload;
  logic                voice_active;
  logic [HANG_W-1:0]   hangover_left;
  logic [SUM_W-1:0]    energy_sum;
  logic [COUNT_W-1:0]  frame_count;
  logic [SAMPLE_W-1:0] sample_q;
  logic                frame_end_q;
  logic [PROD_W-1:0]   prod;

  logic [MAG_W-1:0]    sample_ext;
  logic [MAG_W-1:0]    sample_mag;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                loud;

  assign stat.in_command = in_command;
  assign stat.frame_end  = frame_end_q;
  assign stat.out_full   = out_valid & ~out_ready;

  // Magnitude in 17 bits so that the most negative sample maps to 32768.
  assign sample_ext = {sample_q[SAMPLE_W-1], sample_q};
  assign sample_mag = sample_q[SAMPLE_W-1] ? (~sample_ext + MAG_W'(1)) : sample_ext;

  always_comb begin
    case (cmd.mul_sel)
      MUL_SQUARE: begin
        mul_a = MUL_A_W'(sample_mag);
        mul_b = sample_mag;
      end
      MUL_THR_SQ: begin
        mul_a = MUL_A_W'(energy_threshold);
        mul_b = MUL_B_W'(energy_threshold);
      end
      MUL_THR_CNT: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(frame_count);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign loud = PROD_W'(energy_sum) > prod;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.load) begin
      sample_q    <= in_sample;
      frame_end_q <= in_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold <= THRESHOLD_RESET;
      hangover_reload  <= HANGOVER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENERGY_THRESHOLD: energy_threshold <= cfg_data[THR_W-1:0];
        REG_HANGOVER_RELOAD:  hangover_reload  <= cfg_data[HANG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_active  <= 1'b0;
      hangover_left <= '0;
      energy_sum    <= '0;
      frame_count   <= '0;
      out_valid     <= 1'b0;
      out_speaking  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.judge_en) begin
        out_valid <= 1'b0;
      end
      if (cmd.load && in_command) begin
        voice_active  <= 1'b0;
        hangover_left <= '0;
        energy_sum    <= '0;
        frame_count   <= '0;
      end
      // Samples past the frame limit are dropped but may still end the frame.
      if (cmd.acc_en && frame_count < FRAME_LIMIT) begin
        energy_sum  <= energy_sum + SUM_W'(prod);
        frame_count <= frame_count + COUNT_W'(1);
      end
      if (cmd.judge_en) begin
        out_valid   <= 1'b1;
        energy_sum  <= '0;
        frame_count <= '0;
        if (loud) begin
          voice_active  <= 1'b1;
          hangover_left <= hangover_reload;
          out_speaking  <= 1'b1;
        end else if (!voice_active) begin
          out_speaking <= 1'b0;
        end else if (HANG_W'(frame_count) >= hangover_left) begin
          voice_active  <= 1'b0;
          hangover_left <= '0;
          out_speaking  <= 1'b0;
        end else begin
          hangover_left <= hangover_left - HANG_W'(frame_count);
          out_speaking  <= 1'b1;
        end
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    frame_count <= FRAME_LIMIT)
    else $error("frame count passed the frame limit");

  a_silence_no_hangover: assert property (@(posedge clk) disable iff (rst)
    !voice_active |-> hangover_left == '0)
    else $error("hangover count left over in silence");

  a_judge_restarts_frame: assert property (@(posedge clk) disable iff (rst)
    cmd.judge_en |=> (energy_sum == '0 && frame_count == '0 && out_valid))
    else $error("frame judgment did not restart the frame and post a result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    cmd.judge_en |=> out_speaking == voice_active)
    else $error("posted speaking flag differs from detector state");

endmodule

// ----- hdl/energy_voice_activity_detector.sv -----
// Energy voice activity detector top level: wires the sequencer to the datapath.
// Each sample is squared and then accumulated; for a sample that ends a frame, the one
// 32x17 multiplier that squared it is then used in turn for the threshold square and the
// threshold-square times sample-count product before the frame is judged. A clear command
// ends in its transfer cycle. A new sample is taken while the previous frame's flag still
// waits on the result channel, and only a frame judgment waits for that channel to drain.
// Configuration writes are taken in every cycle.
module energy_voice_activity_detector (
  input logic clk,
  input logic rst,
  evad_in_if.sink    samples,
  evad_out_if.source result,
  evad_cfg_if.sink   cfg
);
  import evad_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  evad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  evad_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (samples.command),
    .in_sample    (samples.sample),
    .in_frame_end (samples.frame_end),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_speaking (result.speaking)
  );

endmodule

// ----- verif/evad_speech_checker.sv -----
// Checker that predicts the per-frame speaking flag and compares it with the result channel.
`timescale 1ns / 1ps
module evad_speech_checker (
  input  logic        clk,
  input  logic        rst,
  evad_in_if          samples,
  evad_out_if         result,
  evad_cfg_if         cfg,
  output int unsigned flag_errors,
  output int unsigned flags_outstanding
);
  import evad_pkg::*;

  logic [THR_W-1:0]   thr_reg;
  logic [HANG_W-1:0]  hang_reg;
  logic               voice_on;
  logic [HANG_W-1:0]  quiet_left;
  logic [SUM_W-1:0]   frame_energy;
  logic [COUNT_W-1:0] frame_len;
  bit                 speaking_due[$];
  int unsigned        err_cnt;

  // Applies one accepted input item and queues the flag a finished frame produces.
  task automatic detect_speech(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                               input logic fe);
    longint          amp;
    longint unsigned bound;
    logic            loud;
    if (cmd) begin
      voice_on     = 1'b0;
      quiet_left   = '0;
      frame_energy = '0;
      frame_len    = '0;
    end else begin
      amp = smp;
      // Samples past the frame limit are dropped, but their end mark still counts.
      if (frame_len < FRAME_LIMIT) begin
        frame_energy = frame_energy + SUM_W'(amp * amp);
        frame_len    = frame_len + COUNT_W'(1);
      end
      if (fe) begin
        bound = 64'(thr_reg) * 64'(thr_reg) * 64'(frame_len);
        loud  = 64'(frame_energy) > bound;
        if (!voice_on) begin
          if (loud) begin
            voice_on   = 1'b1;
            quiet_left = hang_reg;
          end
        end else if (loud) begin
          quiet_left = hang_reg;
        end else if (HANG_W'(frame_len) >= quiet_left) begin
          voice_on   = 1'b0;
          quiet_left = '0;
        end else begin
          quiet_left = quiet_left - HANG_W'(frame_len);
        end
        frame_energy = '0;
        frame_len    = '0;
        speaking_due.push_back(voice_on);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    bit want;
    if (rst) begin
      thr_reg      = THRESHOLD_RESET;
      hang_reg     = HANGOVER_RESET;
      voice_on     = 1'b0;
      quiet_left   = '0;
      frame_energy = '0;
      frame_len    = '0;
      speaking_due.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (speaking_due.size() == 0) begin
          err_cnt++;
          $display("%0t: speaking flag with none expected, expected none, actual %0b",
                   $time, result.speaking);
        end else begin
          want = speaking_due.pop_front();
          if (result.speaking !== want) begin
            err_cnt++;
            $display("%0t: speaking mismatch, expected %0b, actual %0b",
                     $time, want, result.speaking);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_ENERGY_THRESHOLD) begin
          thr_reg = cfg.data[THR_W-1:0];
        end else if (cfg.index == REG_HANGOVER_RELOAD) begin
          hang_reg = cfg.data[HANG_W-1:0];
        end
      end
      if (samples.valid && samples.ready) begin
        detect_speech(samples.command, samples.sample, samples.frame_end);
      end
    end
    flag_errors       <= err_cnt;
    flags_outstanding <= speaking_due.size();
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top: clock, reset, sample and register stimulus, and the final verdict.
`timescale 1ns / 1ps
module tb;
  import evad_pkg::*;

  typedef enum {
    FRAME_FULL,
    FRAME_AT_THR,
    FRAME_ABOVE_THR,
    FRAME_QUIET,
    FRAME_LOUD
  } frame_kind_t;

  logic        clk;
  logic        rst;
  bit          gaps_on;
  int          stall_left;
  int          items_sent;
  int unsigned flag_errors;
  int unsigned flags_outstanding;

  evad_in_if  samples_ch ();
  evad_out_if result_ch ();
  evad_cfg_if cfg_ch ();

  energy_voice_activity_detector i_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .result  (result_ch),
    .cfg     (cfg_ch)
  );

  evad_speech_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .samples           (samples_ch),
    .result            (result_ch),
    .cfg               (cfg_ch),
    .flag_errors       (flag_errors),
    .flags_outstanding (flags_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("FAIL energy_voice_activity_detector");
    $finish;
  end

  // Result side: random stall bursts while gaps are enabled.
  initial begin
    result_ch.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Valid is left high after a transfer so back-to-back items need no extra edge.
  task automatic put_item(input logic cmd, input logic signed [SAMPLE_W-1:0] smp,
                          input logic fe);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    samples_ch.valid     <= 1'b1;
    samples_ch.command   <= cmd;
    samples_ch.sample    <= smp;
    samples_ch.frame_end <= fe;
    do @(posedge clk); while (!samples_ch.ready);
    items_sent++;
  endtask

  // Holds the sender off until every flag has arrived and the datapath has settled.
  task automatic wait_for_flags();
    samples_ch.valid <= 1'b0;
    do @(posedge clk); while (flags_outstanding != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_detector(input int unsigned thr, input int unsigned hang);
    wait_for_flags();
    write_reg(REG_ENERGY_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_HANGOVER_RELOAD, CFG_DATA_W'(hang));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_frame(input frame_kind_t kind, input int len, input int thr);
    int lim;
    int mag;
    logic signed [SAMPLE_W-1:0] smp;
    case (kind)
      FRAME_AT_THR:    lim = thr;
      FRAME_ABOVE_THR: lim = thr + 1;
      FRAME_QUIET:     lim = $urandom_range(0, thr);
      default:         lim = $urandom_range(thr, 3 * thr + 2);
    endcase
    if (lim > 32768) lim = 32768;
    for (int k = 0; k < len; k++) begin
      // Occasional clear commands break the frame in the middle.
      if ($urandom_range(0, 99) < 3) put_item(1'b1, SAMPLE_W'($urandom), 1'($urandom));
      if (kind == FRAME_AT_THR || kind == FRAME_ABOVE_THR) mag = lim;
      else mag = $urandom_range(0, lim);
      if (kind == FRAME_FULL) smp = SAMPLE_W'($urandom);
      else if (mag == 32768) smp = 16'h8000;
      else smp = SAMPLE_W'($urandom_range(0, 1) ? -mag : mag);
      put_item(1'b0, smp, k == len - 1);
    end
  endtask

  task automatic run_random(input int thr, input int n);
    int          start;
    int          len;
    frame_kind_t kind;
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(0, 9))
        0:       kind = FRAME_FULL;
        1:       kind = FRAME_AT_THR;
        2:       kind = FRAME_ABOVE_THR;
        3, 4, 5: kind = FRAME_QUIET;
        default: kind = FRAME_LOUD;
      endcase
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      send_frame(kind, len, thr);
      if ($urandom_range(0, 39) == 0) wait_for_flags();
    end
  endtask

  initial begin : stimulus
    int thr;
    rst                  <= 1'b1;
    samples_ch.valid     <= 1'b0;
    samples_ch.command   <= 1'b0;
    samples_ch.sample    <= '0;
    samples_ch.frame_end <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_ENERGY_THRESHOLD;
    cfg_ch.data          <= '0;
    gaps_on    = 1'b1;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extremes of the sample, clears, and the exact threshold boundary.
    put_item(1'b0, 16'sd0, 1'b1);
    put_item(1'b0, 16'h8000, 1'b1);
    put_item(1'b1, 16'sd32767, 1'b1);
    put_item(1'b0, 16'sd32767, 1'b1);
    put_item(1'b0, 16'sd0, 1'b0);
    put_item(1'b0, 16'sd0, 1'b1);
    put_item(1'b1, 16'sd0, 1'b0);
    put_item(1'b0, 16'sd500, 1'b0);
    put_item(1'b0, -16'sd500, 1'b1);
    put_item(1'b0, 16'sd501, 1'b1);

    // Zero hangover: one quiet frame after a loud one returns to silence.
    set_detector(0, 0);
    put_item(1'b0, 16'sd1, 1'b1);
    put_item(1'b0, 16'sd0, 1'b1);
    put_item(1'b0, 16'sd0, 1'b1);

    // Threshold beyond the usual range, then the largest usual threshold.
    set_detector(65535, 1048575);
    put_item(1'b0, 16'h8000, 1'b0);
    put_item(1'b0, 16'h8000, 1'b1);
    set_detector(32768, 3);
    put_item(1'b0, 16'h8000, 1'b1);

    set_detector(700, 60);
    run_random(700, 300);
    set_detector(0, 0);
    run_random(0, 150);
    set_detector(65535, $urandom_range(0, 1048575));
    run_random(65535, 150);
    set_detector(32768, 1048575);
    run_random(32768, 150);
    thr = $urandom_range(1, 3000);
    set_detector(thr, $urandom_range(0, 200));
    gaps_on = 1'b0;
    run_random(thr, 300);
    gaps_on = 1'b1;
    thr = $urandom_range(1, 3000);
    set_detector(thr, 0);
    run_random(thr, 200);
    thr = $urandom_range(0, 2000);
    set_detector(thr, $urandom_range(0, 100000));
    run_random(thr, 200);
    thr = $urandom_range(100, 1500);
    set_detector(thr, $urandom_range(0, 150));
    gaps_on = 1'b0;
    run_random(thr, 450);

    wait_for_flags();
    repeat (20) @(posedge clk);
    if (flag_errors == 0 && flags_outstanding == 0) begin
      $display("PASS energy_voice_activity_detector");
    end else begin
      $display("FAIL energy_voice_activity_detector");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/evad_pkg.sv
hdl/evad_if.sv
hdl/evad_ctrl.sv
hdl/evad_dp.sv
hdl/energy_voice_activity_detector.sv
verif/evad_speech_checker.sv
verif/tb.sv
